### design/lcts_pkg.sv
package lcts_pkg;

  localparam int KEEP_DEPTH = 16;
  localparam int IDX_W      = 4;   // index into the kept list
  localparam int CNT_W      = 5;   // kept count, 0..KEEP_DEPTH
  localparam int SCORE_W    = 19;
  localparam int DIST_W     = 25;
  localparam int RAD_W      = 50;
  localparam int QUO_W      = 14;  // distance term never exceeds 12800

  localparam logic [24:0] DIST_NUM  = 25'd32768000;  // 500 * 65536
  localparam logic [25:0] DIST_BIAS = 26'd2560;      // 10.0 in Q.8

  localparam logic [1:0] CFG_CAM_X      = 2'd0;
  localparam logic [1:0] CFG_CAM_Y      = 2'd1;
  localparam logic [1:0] CFG_VIEW_DIST  = 2'd2;
  localparam logic [1:0] CFG_MAX_LIGHTS = 2'd3;

  typedef struct packed {
    logic [15:0]        light_id;
    logic               enabled;
    logic               always_visible;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [15:0]        radius;
    logic [11:0]        intensity;
    logic [9:0]         priority_req;
    logic               last_light;
  } in_t;

  typedef struct packed {
    logic [15:0] chosen_id;
    logic        empty_res;
    logic        last_out;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQX, ST_SQY, ST_RSTART, ST_ROOT, ST_DSTART, ST_DIV,
    ST_WALK, ST_INSERT, ST_FINISH, ST_EMIT
  } state_t;

endpackage

### design/lcts_isqrt.sv
module lcts_isqrt
  import lcts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [DIST_W-1:0] root
);

  logic              busy_r;
  logic              done_r;
  logic [4:0]        cnt_r;
  logic [RAD_W-1:0]  rad_r;
  logic [25:0]       rem_r;
  logic [DIST_W-1:0] root_r;
  logic [27:0]       rem_sh;
  logic [27:0]       trial;
  logic              ge;

  // Two radicand bits per step, one root bit out.
  assign rem_sh = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd24;
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rem_r  <= ge ? 26'(rem_sh - trial) : rem_sh[25:0];
        root_r <= {root_r[DIST_W-2:0], ge};
        rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
        cnt_r  <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

### design/lcts_div.sv
module lcts_div
  import lcts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [24:0]       dividend,
  input  logic [25:0]       divisor,
  output logic              done,
  output logic [QUO_W-1:0]  quotient
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [24:0] dvd_r;
  logic [25:0] dvs_r;
  logic [25:0] rem_r;
  logic [24:0] quo_r;
  logic [26:0] sh;
  logic        ge;

  assign sh = {rem_r, dvd_r[24]};
  assign ge = (sh >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd24;
        dvd_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
        quo_r  <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? 26'(sh - {1'b0, dvs_r}) : sh[25:0];
        quo_r <= {quo_r[23:0], ge};
        dvd_r <= {dvd_r[23:0], 1'b0};
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r[QUO_W-1:0];

endmodule

### design/light_cull_top_k_select.sv
// Light cull with top-k selection.
// Input channel in_valid/in_ready/in_data carries one light entry per item.
// Output channel out_valid/out_ready/out_data carries chosen ids, best
// score first; the last id of a pass has last_out set, and a pass with no
// selected light gives one item with empty_res set and chosen_id zero.
// cfg_wr_en/cfg_addr/cfg_wdata writes cam_x, cam_y, view_dist, max_lights.
// Per item: a disabled entry goes straight to the finish state; an
// always-visible entry walks the kept list, then inserts; a positional
// entry squares x and y, takes the root and finishes if out of view, else
// divides, walks the kept list and inserts. The 25-step root and the
// 25-step divide follow one 25x25 multiplier shared by the x and y squares.
// On the last entry of a pass the ids drain one per cycle through the
// output register; a stalled receiver holds the drain, and a new item is
// accepted only after the drain ends. The first result of a pass is
// registered in the emit state, which follows its last entry's finish state.
// Reset clears the kept count, the configuration (max_lights = 8) and the
// output valid; kept list contents need no clearing.
module light_cull_top_k_select
  import lcts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [23:0] cfg_wdata
);

  state_t state_r, state_nxt;

  logic signed [23:0] cam_x_r, cam_y_r;
  logic [23:0]        view_dist_r;
  logic [4:0]         max_lights_r;
  logic [CNT_W-1:0]   cap;

  in_t                item_r;
  logic [DIST_W-1:0]  ax_r, ay_r;
  logic [RAD_W-1:0]   sum_r;
  logic [DIST_W-1:0]  dist_r;
  logic [SCORE_W-1:0] score_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   idx_r;
  logic [15:0]        ids_r    [KEEP_DEPTH];
  logic [SCORE_W-1:0] scores_r [KEEP_DEPTH];
  logic               out_valid_r;
  out_t               out_r;

  logic signed [24:0] dx, dy;
  logic [DIST_W-1:0]  mul_op;
  logic [RAD_W-1:0]   prod;
  logic               visible;
  logic               walk_more;
  logic               out_free;
  logic [CNT_W-1:0]   ins_n;
  logic               sq_start, sq_done, dv_start, dv_done;
  logic [DIST_W-1:0]  root;
  logic [QUO_W-1:0]   quo;

  assign cap = (max_lights_r > 5'(KEEP_DEPTH)) ? 5'(KEEP_DEPTH) : max_lights_r;

  assign dx = 25'(in_data.pos_x) - 25'(cam_x_r);
  assign dy = 25'(in_data.pos_y) - 25'(cam_y_r);

  // One multiplier squares x, then y.
  assign mul_op = (state_r == ST_SQX) ? ax_r : ay_r;
  assign prod   = RAD_W'(mul_op) * RAD_W'(mul_op);

  assign visible = (26'(dist_r) <= (26'(view_dist_r) + 26'(item_r.radius)));

  assign walk_more = (idx_r < count_r) && (scores_r[idx_r[IDX_W-1:0]] >= score_r);
  assign out_free  = !out_valid_r || out_ready;
  assign ins_n     = (count_r < cap) ? count_r + 5'd1 : cap;

  lcts_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sum_r),
    .done     (sq_done),
    .root     (root)
  );

  lcts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend (DIST_NUM),
    .divisor  (26'(dist_r) + DIST_BIAS),
    .done     (dv_done),
    .quotient (quo)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (!in_data.enabled) state_nxt = ST_FINISH;
          else if (in_data.always_visible) state_nxt = ST_WALK;
          else state_nxt = ST_SQX;
        end
      end
      ST_SQX:    state_nxt = ST_SQY;
      ST_SQY:    state_nxt = ST_RSTART;
      ST_RSTART: state_nxt = ST_ROOT;
      ST_ROOT:   if (sq_done) state_nxt = ST_DSTART;
      ST_DSTART: state_nxt = visible ? ST_DIV : ST_FINISH;
      ST_DIV:    if (dv_done) state_nxt = ST_WALK;
      ST_WALK:   if (!walk_more) state_nxt = ST_INSERT;
      ST_INSERT: state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = item_r.last_light ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (out_free && (count_r == '0 || idx_r + 5'd1 == count_r)) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready = (state_r == ST_IDLE);
    sq_start = (state_r == ST_RSTART);
    dv_start = (state_r == ST_DSTART) && visible;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cam_x_r      <= '0;
      cam_y_r      <= '0;
      view_dist_r  <= '0;
      max_lights_r <= 5'd8;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        case (cfg_addr)
          CFG_CAM_X:      cam_x_r      <= cfg_wdata;
          CFG_CAM_Y:      cam_y_r      <= cfg_wdata;
          CFG_VIEW_DIST:  view_dist_r  <= cfg_wdata;
          CFG_MAX_LIGHTS: max_lights_r <= cfg_wdata[4:0];
          default: ;
        endcase
      end
      // Load a new result while draining, else drop valid once taken.
      if (state_r == ST_EMIT && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            item_r  <= in_data;
            ax_r    <= dx[24] ? 25'(-dx) : 25'(dx);
            ay_r    <= dy[24] ? 25'(-dy) : 25'(dy);
            dist_r  <= '0;
            idx_r   <= '0;
            score_r <= {in_data.priority_req, 8'd0}
                       + SCORE_W'({in_data.intensity, 3'd0})
                       + SCORE_W'({in_data.intensity, 1'b0});
            // Drop entries past a lowered limit.
            if (count_r > cap) count_r <= cap;
          end
        end
        ST_SQX: sum_r <= prod;
        ST_SQY: sum_r <= sum_r + prod;
        ST_ROOT: if (sq_done) dist_r <= root;
        ST_DIV:  if (dv_done) score_r <= score_r + SCORE_W'(quo);
        ST_WALK: if (walk_more) idx_r <= idx_r + 5'd1;
        ST_INSERT: begin
          if (idx_r < cap) begin
            for (int k = 0; k < KEEP_DEPTH; k++) begin
              if (5'(k) == idx_r) begin
                ids_r[k]    <= item_r.light_id;
                scores_r[k] <= score_r;
              end else if (5'(k) > idx_r && k > 0) begin
                ids_r[k]    <= ids_r[k-1];
                scores_r[k] <= scores_r[k-1];
              end
            end
            count_r <= ins_n;
          end
        end
        ST_FINISH: idx_r <= '0;
        ST_EMIT: begin
          if (out_free) begin
            if (count_r == '0) begin
              out_r.chosen_id <= '0;
              out_r.empty_res <= 1'b1;
              out_r.last_out  <= 1'b1;
            end else begin
              out_r.chosen_id <= ids_r[idx_r[IDX_W-1:0]];
              out_r.empty_res <= 1'b0;
              out_r.last_out  <= (idx_r + 5'd1 == count_r);
              idx_r           <= idx_r + 5'd1;
              if (idx_r + 5'd1 == count_r) count_r <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 5'(KEEP_DEPTH))
    else $error("kept count past depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted two items back to back");

  a_empty_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.empty_res |-> out_data.chosen_id == 16'd0 && out_data.last_out)
    else $error("empty result carries an id");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && state_nxt == ST_IDLE |=> count_r == '0)
    else $error("kept list not cleared after a pass");
`endif

endmodule

### tb/light_cull_top_k_select_tb.sv
`timescale 1ns / 1ps

module light_cull_top_k_select_tb;
  import lcts_pkg::*;

  // Selection predictor and result checker: keeps its own camera setup and
  // sorted kept list, and queues the ids each pass should emit.
  class light_select_sb;
    logic signed [23:0] cam_x, cam_y;
    logic [23:0]        view_dist;
    logic [4:0]         max_lights;
    logic [15:0]        kept_id[KEEP_DEPTH];
    logic [18:0]        kept_score[KEEP_DEPTH];
    int                 kept_cnt;
    out_t               id_q[$];
    int                 mismatches, results, items, passes;

    function void reset_state();
      cam_x = '0; cam_y = '0; view_dist = '0; max_lights = 5'd8;
      kept_cnt = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [23:0] val);
      case (idx)
        CFG_CAM_X:      cam_x = val;
        CFG_CAM_Y:      cam_y = val;
        CFG_VIEW_DIST:  view_dist = val;
        CFG_MAX_LIGHTS: max_lights = val[4:0];
        default: ;
      endcase
    endfunction

    function longint unsigned int_root(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void note_light(in_t d);
      int cap, p, n;
      longint dx, dy;
      longint unsigned dlen, score;
      bit vis;
      out_t r;
      items++;
      cap = (max_lights > KEEP_DEPTH) ? KEEP_DEPTH : max_lights;
      if (kept_cnt > cap) kept_cnt = cap;
      if (d.enabled) begin
        vis = 1;
        score = (longint'(d.priority_req) << 8) + 10 * longint'(d.intensity);
        if (!d.always_visible) begin
          dx = longint'(d.pos_x) - longint'(cam_x);
          dy = longint'(d.pos_y) - longint'(cam_y);
          dlen = int_root(dx * dx + dy * dy);
          vis = dlen <= longint'(view_dist) + longint'(d.radius);
          score += 64'd32768000 / (64'd2560 + dlen);
        end
        if (vis) begin
          p = 0;
          // ties go behind equal scores
          while (p < kept_cnt && kept_score[p] >= score[18:0]) p++;
          if (p < cap) begin
            n = (kept_cnt < cap) ? kept_cnt + 1 : cap;
            for (int k = n - 1; k > p; k--) begin
              kept_id[k] = kept_id[k-1];
              kept_score[k] = kept_score[k-1];
            end
            kept_id[p] = d.light_id;
            kept_score[p] = score[18:0];
            kept_cnt = n;
          end
        end
      end
      if (!d.last_light) return;
      passes++;
      if (kept_cnt == 0) begin
        r.chosen_id = '0; r.empty_res = 1'b1; r.last_out = 1'b1;
        id_q = {id_q, r};
      end else begin
        for (int k = 0; k < kept_cnt; k++) begin
          r.chosen_id = kept_id[k]; r.empty_res = 1'b0;
          r.last_out = (k == kept_cnt - 1);
          id_q = {id_q, r};
        end
        kept_cnt = 0;
      end
    endfunction

    function void check_result(out_t got);
      out_t exp_r;
      results++;
      if (id_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: id=%0d empty=%0b last=%0b",
                   got.chosen_id, got.empty_res, got.last_out);
        return;
      end
      exp_r = id_q.pop_front();
      if (got.chosen_id !== exp_r.chosen_id || got.empty_res !== exp_r.empty_res ||
          got.last_out !== exp_r.last_out) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected id=%0d empty=%0b last=%0b, got id=%0d empty=%0b last=%0b",
                   exp_r.chosen_id, exp_r.empty_res, exp_r.last_out,
                   got.chosen_id, got.empty_res, got.last_out);
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_valid, in_ready, out_valid, out_ready;
  in_t         in_data;
  out_t        out_data;
  logic        cfg_wr_en;
  logic [1:0]  cfg_addr;
  logic [23:0] cfg_wdata;

  light_select_sb sb;
  int in_idle_pct, out_idle_pct;

  light_cull_top_k_select u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

  // Receiver: stall at random according to the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Track every accepted light and every accepted result.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_light(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Drive one light entry; hold valid and payload until accepted.
  task automatic send_light(in_t d);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
  endtask

  // Wait until every queued id has come out, then let the block settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.id_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // Write one register, then hold the enable low before returning.
  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [23:0] near(logic signed [23:0] c, int span);
    int v;
    v = int'(c) + int'($urandom_range(2 * span)) - span;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  // Build a random light: mostly plausible entries around the camera.
  function automatic in_t make_light(bit last, int span);
    in_t d;
    int kind;
    d = '0;
    d.light_id     = 16'($urandom);
    d.intensity    = 12'($urandom);
    d.priority_req = 10'($urandom);
    d.radius       = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1024));
    d.enabled      = 1'b1;
    d.last_light   = last;
    kind = $urandom_range(99);
    if (kind < 10) begin
      d.enabled = 1'b0;
    end else if (kind < 35) begin
      d.always_visible = 1'b1;
    end else if (kind < 90) begin
      d.always_visible = 1'b0;
      d.pos_x = near(sb.cam_x, span);
      d.pos_y = near(sb.cam_y, span);
    end else begin
      d.pos_x = 24'($urandom);
      d.pos_y = 24'($urandom);
    end
    return d;
  endfunction

  function automatic in_t fixed_light(logic [15:0] id, bit always_on, logic [9:0] prio,
                                      logic [11:0] inten, bit last);
    in_t d;
    d = '0;
    d.light_id = id; d.enabled = 1'b1; d.always_visible = always_on;
    d.priority_req = prio; d.intensity = inten; d.last_light = last;
    return d;
  endfunction

  task automatic random_pass();
    int len, span;
    in_t d;
    if ($urandom_range(3) == 0) begin
      write_reg(CFG_CAM_X, 24'($urandom));
      write_reg(CFG_CAM_Y, 24'($urandom));
    end
    if ($urandom_range(2) == 0)
      write_reg(CFG_VIEW_DIST, ($urandom_range(4) == 0) ? 24'($urandom)
                                                        : 24'($urandom_range(3000)));
    if ($urandom_range(2) == 0)
      write_reg(CFG_MAX_LIGHTS, ($urandom_range(3) == 0) ? 24'($urandom_range(31))
                                                         : 24'($urandom_range(1, 8)));
    len  = ($urandom_range(9) == 0) ? 20 : $urandom_range(1, 10);
    span = $urandom_range(4000);
    for (int i = 0; i < len; i++) begin
      // now and then, shrink the limit halfway through a pass
      if (i == len / 2 && len > 3 && $urandom_range(19) == 0) begin
        wait_idle();
        write_reg(CFG_MAX_LIGHTS, 24'($urandom_range(0, 3)));
      end
      d = make_light(i == len - 1, span);
      send_light(d);
    end
    wait_idle();
  endtask

  initial begin
    in_t d;
    sb = new();
    sb.reset_state();
    in_valid = 1'b0; in_data = '0; out_ready = 1'b0;
    cfg_wr_en = 1'b0; cfg_addr = CFG_CAM_X; cfg_wdata = '0;
    in_idle_pct = 26; out_idle_pct = 73;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pass at reset settings, via a disabled last entry.
    d = fixed_light(16'd5, 1'b1, 10'd1, 12'd0, 1'b1);
    d.enabled = 1'b0;
    send_light(d);
    wait_idle();

    // Ties keep arrival order; id zero and id all-ones; strongest first.
    send_light(fixed_light(16'd0, 1'b1, 10'd7, 12'd3, 1'b0));
    send_light(fixed_light(16'hFFFF, 1'b1, 10'd7, 12'd3, 1'b0));
    send_light(fixed_light(16'd9, 1'b1, 10'd1023, 12'hFFF, 1'b0));
    send_light(fixed_light(16'd10, 1'b1, 10'd0, 12'd0, 1'b1));
    wait_idle();

    // Camera and distance extremes: far light out of view, near one in.
    write_reg(CFG_CAM_X, 24'h800000);
    write_reg(CFG_CAM_Y, 24'h7FFFFF);
    write_reg(CFG_VIEW_DIST, 24'hFFFFFF);
    d = fixed_light(16'd20, 1'b0, 10'd3, 12'd1, 1'b0);
    d.pos_x = 24'sh7FFFFF; d.pos_y = -24'sd8388608; d.radius = 16'hFFFF;
    send_light(d);
    d = fixed_light(16'd21, 1'b0, 10'd3, 12'd1, 1'b0);
    d.pos_x = 24'sh800000; d.pos_y = 24'sh7FFFFF;
    send_light(d);
    wait_idle();
    write_reg(CFG_VIEW_DIST, 24'd0);
    // invisible last entry still closes the pass
    d = fixed_light(16'd22, 1'b0, 10'd3, 12'd1, 1'b1);
    d.pos_x = 24'sd0; d.pos_y = 24'sd0;
    send_light(d);
    wait_idle();

    // Zero limit gives the empty result.
    write_reg(CFG_MAX_LIGHTS, 24'd0);
    send_light(fixed_light(16'd30, 1'b1, 10'd5, 12'd5, 1'b0));
    send_light(fixed_light(16'd31, 1'b1, 10'd5, 12'd5, 1'b1));
    wait_idle();

    // Limit above range saturates to the full list.
    write_reg(CFG_MAX_LIGHTS, 24'd31);
    for (int i = 0; i < 18; i++)
      send_light(fixed_light(16'(40 + i), 1'b1, 10'($urandom), 12'($urandom), i == 17));
    wait_idle();

    // Limit lowered mid-pass truncates the kept list.
    write_reg(CFG_MAX_LIGHTS, 24'd16);
    for (int i = 0; i < 4; i++)
      send_light(fixed_light(16'(60 + i), 1'b1, 10'(100 * i), 12'd0, 1'b0));
    wait_idle();
    write_reg(CFG_MAX_LIGHTS, 24'd2);
    send_light(fixed_light(16'd70, 1'b1, 10'd0, 12'd0, 1'b1));
    wait_idle();

    write_reg(CFG_CAM_X, 24'd0);
    write_reg(CFG_CAM_Y, 24'd0);
    write_reg(CFG_MAX_LIGHTS, 24'd8);

    // Random passes in three idling phases.
    while (sb.items < 130) random_pass();
    in_idle_pct = 73; out_idle_pct = 26;
    while (sb.items < 230) random_pass();
    in_idle_pct = 0; out_idle_pct = 0;
    while (sb.items < 300) random_pass();

    in_valid <= 1'b0;
    wait_idle();
    if (sb.id_q.size() != 0) sb.mismatches += sb.id_q.size();
    $display("covered %0d light items in %0d cull passes, %0d ids checked",
             sb.items, sb.passes, sb.results);
    $display("mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
